// ----- rtl/stc_pkg.sv -----
// ============================================================================
// stc_pkg
// Shared types, constants and codes of the scrolling tile map and sprite
// compositor.
// ============================================================================
package stc_pkg;

    // Default sizes of the stores
    localparam int MAP_COLUMNS_DEF   = 256;
    localparam int MAP_ROW_COUNT_DEF = 15;
    localparam int TILE_KINDS_DEF    = 16;

    // Tile geometry and screen size
    localparam int TILE_EDGE     = 16;
    localparam int TILE_EDGE_W   = $clog2(TILE_EDGE);
    localparam int TILE_AREA     = TILE_EDGE * TILE_EDGE;
    localparam int TILE_AREA_W   = 2 * TILE_EDGE_W;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // Widths of internal values
    localparam int MX_W       = 13;                 // scroll_x + pos_x
    localparam int TCOL_W     = MX_W - TILE_EDGE_W; // map column of a render
    localparam int DX_W       = MX_W + 2;           // signed sprite offset in x
    localparam int DY_W       = 10;                 // signed sprite offset in y
    localparam int MAP_AW_MAX = 14;                 // 15 rows of 1024 columns

    // Queue depths
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 4;

    // Colours
    localparam logic [15:0] CLEAR_RESET = 16'h5DFF;
    localparam logic [15:0] KEY_COLOUR  = 16'h0000;

    // Configuration register indexes
    localparam logic [1:0] REG_CAMERA_X   = 2'd0;
    localparam logic [1:0] REG_SPRITE_X   = 2'd1;
    localparam logic [1:0] REG_SPRITE_Y   = 2'd2;
    localparam logic [1:0] REG_BACKGROUND = 2'd3;

    typedef enum logic [1:0] {
        OP_MAP_WR    = 2'd0,
        OP_TILE_WR   = 2'd1,
        OP_SPRITE_WR = 2'd2,
        OP_RENDER    = 2'd3
    } op_t;

    typedef struct packed {
        logic [11:0] scroll_x;
        logic [12:0] sprite_x;          // two's complement
        logic [8:0]  sprite_y;          // two's complement
        logic [15:0] background_colour;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [3:0]  map_row;
        logic [7:0]  map_column;
        logic [3:0]  tile_number;
        logic [7:0]  pixel_index;
        logic [15:0] colour_value;
        logic [8:0]  pos_x;
        logic [7:0]  pos_y;
    } in_t;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        op_t                    kind;
        logic [MAP_AW_MAX-1:0]  map_addr;
        logic                   map_en;     // render falls inside the map
        logic [3:0]             tile_num;
        logic [TILE_AREA_W-1:0] pix_off;    // pixel inside a tile
        logic                   spr_in;     // render falls inside the sprite box
        logic [TILE_AREA_W-1:0] spr_off;    // pixel inside the sprite
        logic [15:0]            colour;
        logic [8:0]             x;
        logic [7:0]             y;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pixel_colour;
        logic [8:0]  out_x;
        logic [7:0]  out_y;
        logic        sprite_hit;
    } res_t;

endpackage

// ----- rtl/stc_ram.sv -----
// ============================================================================
// stc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ============================================================================
module stc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stc_queue.sv -----
// ============================================================================
// stc_queue
// Small register FIFO with an occupancy count.
// ============================================================================
module stc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       not_empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign count     = count_reg;

endmodule

// ----- rtl/stc_front.sv -----
// ============================================================================
// stc_front
// Front end: decodes each request, drops the ones that have no effect and
// works out store addresses, map position and sprite box test.
// ============================================================================
module stc_front #(
    parameter int MAP_COLUMNS   = stc_pkg::MAP_COLUMNS_DEF,
    parameter int MAP_ROW_COUNT = stc_pkg::MAP_ROW_COUNT_DEF,
    parameter int TILE_KINDS    = stc_pkg::TILE_KINDS_DEF
) (
    input  logic          in_accept,
    input  stc_pkg::in_t  in_item,
    input  stc_pkg::cfg_t cfg,
    output logic          push,
    output stc_pkg::cmd_t cmd
);

    localparam int TEW = stc_pkg::TILE_EDGE_W;
    localparam int AWM = stc_pkg::MAP_AW_MAX;

    logic [stc_pkg::MX_W-1:0]   mx;
    logic [stc_pkg::TCOL_W-1:0] tcol;
    logic [3:0]                 trow;
    logic signed [stc_pkg::DX_W-1:0] dx;
    logic signed [stc_pkg::DY_W-1:0] dy;
    logic [3:0]                 row_sel;
    logic [stc_pkg::TCOL_W-1:0] col_sel;
    logic                       keep;

    always_comb
    begin
        mx   = stc_pkg::MX_W'(cfg.scroll_x) + stc_pkg::MX_W'(in_item.pos_x);
        tcol = mx[stc_pkg::MX_W-1:TEW];
        trow = in_item.pos_y[7:TEW];
        dx   = $signed({2'b00, mx})
             - $signed({{2{cfg.sprite_x[12]}}, cfg.sprite_x});
        dy   = $signed({2'b00, in_item.pos_y})
             - $signed({cfg.sprite_y[8], cfg.sprite_y});

        if (in_item.opcode == stc_pkg::OP_RENDER)
        begin
            row_sel = trow;
            col_sel = tcol;
        end
        else
        begin
            row_sel = in_item.map_row;
            col_sel = stc_pkg::TCOL_W'(in_item.map_column);
        end

        cmd.kind     = in_item.opcode;
        cmd.map_addr = AWM'(row_sel) * AWM'(MAP_COLUMNS) + AWM'(col_sel);
        cmd.map_en   = (32'(tcol) < MAP_COLUMNS) && (32'(trow) < MAP_ROW_COUNT);
        cmd.tile_num = in_item.tile_number;
        cmd.spr_in   = (dx[stc_pkg::DX_W-1:TEW] == '0) && (dy[stc_pkg::DY_W-1:TEW] == '0);
        cmd.colour   = in_item.colour_value;
        cmd.x        = in_item.pos_x;
        cmd.y        = in_item.pos_y;

        if (in_item.opcode == stc_pkg::OP_RENDER)
        begin
            cmd.pix_off = {in_item.pos_y[TEW-1:0], mx[TEW-1:0]};
            cmd.spr_off = {dy[TEW-1:0], dx[TEW-1:0]};
        end
        else
        begin
            cmd.pix_off = in_item.pixel_index;
            cmd.spr_off = in_item.pixel_index;
        end

        unique case (in_item.opcode)
            stc_pkg::OP_MAP_WR:
                keep = (32'(in_item.map_row) < MAP_ROW_COUNT)
                    && (32'(in_item.map_column) < MAP_COLUMNS);
            stc_pkg::OP_TILE_WR:
                keep = (32'(in_item.tile_number) < TILE_KINDS);
            stc_pkg::OP_SPRITE_WR:
                keep = 1'b1;
            stc_pkg::OP_RENDER:
                keep = (32'(in_item.pos_x) < stc_pkg::SCREEN_WIDTH)
                    && (32'(in_item.pos_y) < stc_pkg::SCREEN_HEIGHT);
            default:
                keep = 1'b0;
        endcase

        push = in_accept && keep;
    end

endmodule

// ----- rtl/stc_back.sv -----
// ============================================================================
// stc_back
// Back end: carries out store writes and runs renders through a three-step
// pipeline (map and sprite read, tile read, compose).
// ============================================================================
module stc_back #(
    parameter int MAP_COLUMNS   = stc_pkg::MAP_COLUMNS_DEF,
    parameter int MAP_ROW_COUNT = stc_pkg::MAP_ROW_COUNT_DEF,
    parameter int TILE_KINDS    = stc_pkg::TILE_KINDS_DEF,
    parameter int OUT_DEPTH     = stc_pkg::OUT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stc_pkg::cfg_t                  cfg,
    input  logic                           q_valid,
    input  stc_pkg::cmd_t                  q_cmd,
    output logic                           q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output stc_pkg::res_t                  out_res
);

    localparam int MAP_DEPTH  = MAP_COLUMNS * MAP_ROW_COUNT;
    localparam int MAW        = $clog2(MAP_DEPTH);
    localparam int TKW        = $clog2(TILE_KINDS);
    localparam int TILE_DEPTH = TILE_KINDS * stc_pkg::TILE_AREA;
    localparam int TAW        = $clog2(TILE_DEPTH);
    localparam int CW         = $clog2(OUT_DEPTH + 1);

    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    stc_pkg::cmd_t cmd1_reg;
    logic          render2_reg;
    logic          tile_ok2_reg;
    logic          spr_in2_reg;
    logic [15:0]   spr_data2_reg;
    logic [8:0]    x2_reg;
    logic [7:0]    y2_reg;

    logic [CW:0]   in_flight;
    logic          pop_render;
    logic          render1;
    logic          tile_ok1;
    logic [3:0]    map_rdata;
    logic [15:0]   spr_rdata;
    logic [15:0]   tile_rdata;
    logic          hit;

    // An output slot is reserved for every item in the pipeline.
    assign in_flight  = (CW + 1)'(out_count) + (CW + 1)'(v1_reg) + (CW + 1)'(v2_reg);
    assign q_pop      = q_valid && (in_flight < (CW + 1)'(OUT_DEPTH));
    assign pop_render = q_pop && (q_cmd.kind == stc_pkg::OP_RENDER);
    assign render1    = v1_reg && (cmd1_reg.kind == stc_pkg::OP_RENDER);
    assign tile_ok1   = render1 && cmd1_reg.map_en && (32'(map_rdata) < TILE_KINDS);
    assign v1_next    = q_pop;
    assign v2_next    = v1_reg;

    stc_ram #(
        .WIDTH (4),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (q_pop && (q_cmd.kind == stc_pkg::OP_MAP_WR)),
        .waddr (q_cmd.map_addr[MAW-1:0]),
        .wdata (q_cmd.tile_num),
        .re    (pop_render && q_cmd.map_en),
        .raddr (q_cmd.map_addr[MAW-1:0]),
        .rdata (map_rdata)
    );

    stc_ram #(
        .WIDTH (16),
        .DEPTH (stc_pkg::TILE_AREA)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (q_pop && (q_cmd.kind == stc_pkg::OP_SPRITE_WR)),
        .waddr (q_cmd.spr_off),
        .wdata (q_cmd.colour),
        .re    (pop_render && q_cmd.spr_in),
        .raddr (q_cmd.spr_off),
        .rdata (spr_rdata)
    );

    stc_ram #(
        .WIDTH (16),
        .DEPTH (TILE_DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .we    (v1_reg && (cmd1_reg.kind == stc_pkg::OP_TILE_WR)),
        .waddr (TAW'({TKW'(cmd1_reg.tile_num), cmd1_reg.pix_off})),
        .wdata (cmd1_reg.colour),
        .re    (tile_ok1),
        .raddr (TAW'({TKW'(map_rdata), cmd1_reg.pix_off})),
        .rdata (tile_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg      <= q_cmd;
        render2_reg   <= render1;
        tile_ok2_reg  <= tile_ok1;
        spr_in2_reg   <= cmd1_reg.spr_in;
        spr_data2_reg <= spr_rdata;
        x2_reg        <= cmd1_reg.x;
        y2_reg        <= cmd1_reg.y;
    end

    always_comb
    begin
        hit = spr_in2_reg && (spr_data2_reg != stc_pkg::KEY_COLOUR);
        if (hit)
        begin
            out_res.pixel_colour = spr_data2_reg;
        end
        else if (tile_ok2_reg)
        begin
            out_res.pixel_colour = tile_rdata;
        end
        else
        begin
            out_res.pixel_colour = cfg.background_colour;
        end
        out_res.out_x      = x2_reg;
        out_res.out_y      = y2_reg;
        out_res.sprite_hit = hit;
        out_push           = v2_reg && render2_reg;
    end

endmodule

// ----- rtl/scrolling_tilemap_sprite_compositor_unit.sv -----
// ============================================================================
// scrolling_tilemap_sprite_compositor_unit
// Composites a scrolled tile map, a color-keyed sprite and a background
// color into RGB565 pixels; write requests load the map, tile and sprite stores.
// ============================================================================
// A render passes the command queue, map and sprite read, tile read and the
// result queue. Throughput: one request per cycle while the queues have room;
// each store takes one access per step: map and sprite first, then tile.
// Reset: registers return to their defaults and the queues empty; the stores
// are not cleared and hold their contents until written.
module scrolling_tilemap_sprite_compositor_unit #(
    parameter int MAP_COLUMNS   = stc_pkg::MAP_COLUMNS_DEF,
    parameter int MAP_ROW_COUNT = stc_pkg::MAP_ROW_COUNT_DEF,
    parameter int TILE_KINDS    = stc_pkg::TILE_KINDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // map_row[3:0], map_column[11:4], tile_number[15:12], pixel_index[23:16],
    // colour_value[39:24], pos_x[48:40], pos_y[56:49], zero[63:57]
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_colour[15:0], out_x[24:16], out_y[32:25], zero[39:33]
    output logic [39:0] m_tdata,
    output logic [0:0]  m_tuser,   // sprite_hit[0]
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int OCW = $clog2(stc_pkg::OUT_DEPTH + 1);
    localparam int ICW = $clog2(stc_pkg::IN_DEPTH + 1);

    stc_pkg::cfg_t cfg_reg, cfg_next;
    stc_pkg::in_t  in_item;
    stc_pkg::cmd_t front_cmd;
    stc_pkg::cmd_t q_cmd;
    stc_pkg::res_t back_res;
    stc_pkg::res_t out_res;

    logic           cfg_wr;
    logic [1:0]     reg_idx;
    logic           in_push;
    logic           in_full;
    logic           q_valid;
    logic           q_pop;
    logic [ICW-1:0] in_count;
    logic           out_push;
    logic           out_full;
    logic [OCW-1:0] out_count;
    logic           out_pop;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                stc_pkg::REG_CAMERA_X:   cfg_next.scroll_x          = pwdata[11:0];
                stc_pkg::REG_SPRITE_X:   cfg_next.sprite_x          = pwdata[12:0];
                stc_pkg::REG_SPRITE_Y:   cfg_next.sprite_y          = pwdata[8:0];
                stc_pkg::REG_BACKGROUND: cfg_next.background_colour = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            stc_pkg::REG_CAMERA_X:   prdata = 32'(cfg_reg.scroll_x);
            stc_pkg::REG_SPRITE_X:   prdata = 32'(cfg_reg.sprite_x);
            stc_pkg::REG_SPRITE_Y:   prdata = 32'(cfg_reg.sprite_y);
            stc_pkg::REG_BACKGROUND: prdata = 32'(cfg_reg.background_colour);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scroll_x          <= '0;
            cfg_reg.sprite_x          <= '0;
            cfg_reg.sprite_y          <= '0;
            cfg_reg.background_colour <= stc_pkg::CLEAR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Request unpacking
    always_comb
    begin
        in_item.opcode       = stc_pkg::op_t'(s_tuser);
        in_item.map_row      = s_tdata[3:0];
        in_item.map_column   = s_tdata[11:4];
        in_item.tile_number  = s_tdata[15:12];
        in_item.pixel_index  = s_tdata[23:16];
        in_item.colour_value = s_tdata[39:24];
        in_item.pos_x        = s_tdata[48:40];
        in_item.pos_y        = s_tdata[56:49];
    end

    assign s_tready = !in_full;

    stc_front #(
        .MAP_COLUMNS   (MAP_COLUMNS),
        .MAP_ROW_COUNT (MAP_ROW_COUNT),
        .TILE_KINDS    (TILE_KINDS)
    ) u_front (
        .in_accept (s_tvalid && s_tready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .push      (in_push),
        .cmd       (front_cmd)
    );

    stc_queue #(
        .WIDTH ($bits(stc_pkg::cmd_t)),
        .DEPTH (stc_pkg::IN_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .not_empty (q_valid),
        .full      (in_full),
        .count     (in_count)
    );

    stc_back #(
        .MAP_COLUMNS   (MAP_COLUMNS),
        .MAP_ROW_COUNT (MAP_ROW_COUNT),
        .TILE_KINDS    (TILE_KINDS),
        .OUT_DEPTH     (stc_pkg::OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_res   (back_res)
    );

    stc_queue #(
        .WIDTH ($bits(stc_pkg::res_t)),
        .DEPTH (stc_pkg::OUT_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (back_res),
        .pop       (out_pop),
        .pop_data  (out_res),
        .not_empty (m_tvalid),
        .full      (out_full),
        .count     (out_count)
    );

    assign out_pop    = m_tvalid && m_tready;
    assign m_tdata    = {7'b0, out_res.out_y, out_res.out_x, out_res.pixel_colour};
    assign m_tuser[0] = out_res.sprite_hit;

    // The back end reserves result space before it takes a command.
    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue written while full");

    a_push_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_push |-> (s_tvalid && s_tready && (in_count != ICW'(stc_pkg::IN_DEPTH))))
        else $error("command queued without an accepted request");

    a_hit_is_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] != stc_pkg::KEY_COLOUR))
        else $error("sprite hit reported with the key color");

endmodule

// ----- tb/scrolling_tilemap_sprite_compositor_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// scrolling_tilemap_sprite_compositor_unit_tb
// Self-checking bench for the tile map and sprite compositor. A queue of
// requests feeds a stream driver; a monitor predicts each render from its own
// copy of the stores and registers and checks every pixel that comes back.
// Renders are only issued once every store entry they read has been loaded.
// ============================================================================
module scrolling_tilemap_sprite_compositor_unit_tb;

    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // map_row[3:0], map_column[11:4], tile_number[15:12], pixel_index[23:16],
    // colour_value[39:24], pos_x[48:40], pos_y[56:49], zero[63:57]
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;     // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pixel_colour[15:0], out_x[24:16], out_y[32:25], zero[39:33]
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;          // sprite_hit[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    scrolling_tilemap_sprite_compositor_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Register copy shared by the pixel predictor and the request planner.
    int cam_cfg   = 0;
    int spr_x_cfg = 0;
    int spr_y_cfg = 0;
    int bg_cfg    = int'(stc_pkg::CLEAR_RESET);

    // Predicted store contents, updated as requests are accepted.
    logic [3:0]  map_tiles     [stc_pkg::MAP_ROW_COUNT_DEF][stc_pkg::MAP_COLUMNS_DEF];
    logic [15:0] tile_pixels   [stc_pkg::TILE_KINDS_DEF][stc_pkg::TILE_AREA];
    logic [15:0] sprite_pixels [stc_pkg::TILE_AREA];

    // Planner view of the stores, updated as requests are queued.
    logic [3:0] plan_map        [stc_pkg::MAP_ROW_COUNT_DEF][stc_pkg::MAP_COLUMNS_DEF];
    bit         plan_map_set    [stc_pkg::MAP_ROW_COUNT_DEF][stc_pkg::MAP_COLUMNS_DEF];
    bit         plan_tile_set   [stc_pkg::TILE_KINDS_DEF][stc_pkg::TILE_AREA];
    bit         plan_sprite_set [stc_pkg::TILE_AREA];

    stc_pkg::in_t  request_queue[$];
    stc_pkg::res_t expected_pixels[$];
    stc_pkg::in_t  drv_req;
    int   queued_requests   = 0;
    int   accepted_requests = 0;
    int   mismatches        = 0;
    int   send_idle_pct     = 0;
    int   recv_stall_pct    = 0;
    int   quiet_cycles      = 0;
    int   hold_left         = 0;
    bit   hold_arm          = 1'b0;
    bit   hold_done         = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] random_colour();
        if ($urandom_range(0, 99) < 15)
            return stc_pkg::KEY_COLOUR;
        return 16'($urandom());
    endfunction

    // All fields random; the ones the opcode does not use are noise.
    function automatic stc_pkg::in_t random_request(stc_pkg::op_t op);
        stc_pkg::in_t r;
        r.opcode       = op;
        r.map_row      = 4'($urandom_range(0, 15));
        r.map_column   = 8'($urandom_range(0, 255));
        r.tile_number  = 4'($urandom_range(0, 15));
        r.pixel_index  = 8'($urandom_range(0, 255));
        r.colour_value = random_colour();
        r.pos_x        = 9'($urandom_range(0, 511));
        r.pos_y        = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic stc_pkg::in_t build(stc_pkg::op_t op, int row, int col, int tile,
                                           int pix, int colour, int x, int y);
        stc_pkg::in_t r;
        r.opcode       = op;
        r.map_row      = row[3:0];
        r.map_column   = col[7:0];
        r.tile_number  = tile[3:0];
        r.pixel_index  = pix[7:0];
        r.colour_value = colour[15:0];
        r.pos_x        = x[8:0];
        r.pos_y        = y[7:0];
        return r;
    endfunction

    // Applies one accepted request to the predicted stores; returns 1 with the
    // composited pixel when the request is an on-screen render.
    function automatic bit composite_pixel(input stc_pkg::in_t req,
                                           output stc_pkg::res_t res);
        int          mx, tcol, trow, dx, dy;
        logic [3:0]  id;
        logic [15:0] colour;
        bit          hit;
        bit          produced;
        res      = '0;
        produced = 1'b0;
        case (req.opcode)
            stc_pkg::OP_MAP_WR:
                if (req.map_row < stc_pkg::MAP_ROW_COUNT_DEF
                    && req.map_column < stc_pkg::MAP_COLUMNS_DEF)
                    map_tiles[req.map_row][req.map_column] = req.tile_number;
            stc_pkg::OP_TILE_WR:
                if (req.tile_number < stc_pkg::TILE_KINDS_DEF)
                    tile_pixels[req.tile_number][req.pixel_index] = req.colour_value;
            stc_pkg::OP_SPRITE_WR:
                sprite_pixels[req.pixel_index] = req.colour_value;
            default:
                if (req.pos_x < stc_pkg::SCREEN_WIDTH
                    && req.pos_y < stc_pkg::SCREEN_HEIGHT) begin
                    mx     = cam_cfg + int'(req.pos_x);
                    tcol   = mx / stc_pkg::TILE_EDGE;
                    trow   = int'(req.pos_y) / stc_pkg::TILE_EDGE;
                    colour = bg_cfg[15:0];
                    hit    = 1'b0;
                    // Columns past the end of the map keep the background.
                    if (tcol < stc_pkg::MAP_COLUMNS_DEF && trow < stc_pkg::MAP_ROW_COUNT_DEF)
                    begin
                        id = map_tiles[trow][tcol];
                        if (id < stc_pkg::TILE_KINDS_DEF)
                            colour = tile_pixels[id][(int'(req.pos_y) % stc_pkg::TILE_EDGE)
                                                     * stc_pkg::TILE_EDGE
                                                     + mx % stc_pkg::TILE_EDGE];
                    end
                    dx = mx - spr_x_cfg;
                    dy = int'(req.pos_y) - spr_y_cfg;
                    if (dx >= 0 && dx < stc_pkg::TILE_EDGE
                        && dy >= 0 && dy < stc_pkg::TILE_EDGE) begin
                        if (sprite_pixels[dy * stc_pkg::TILE_EDGE + dx]
                            != stc_pkg::KEY_COLOUR) begin
                            colour = sprite_pixels[dy * stc_pkg::TILE_EDGE + dx];
                            hit    = 1'b1;
                        end
                    end
                    res.pixel_colour = colour;
                    res.out_x        = req.pos_x;
                    res.out_y        = req.pos_y;
                    res.sprite_hit   = hit;
                    produced         = 1'b1;
                end
        endcase
        return produced;
    endfunction

    task automatic push_request(stc_pkg::in_t r);
        case (r.opcode)
            stc_pkg::OP_MAP_WR:
                if (r.map_row < stc_pkg::MAP_ROW_COUNT_DEF) begin
                    plan_map[r.map_row][r.map_column]     = r.tile_number;
                    plan_map_set[r.map_row][r.map_column] = 1'b1;
                end
            stc_pkg::OP_TILE_WR:
                if (r.tile_number < stc_pkg::TILE_KINDS_DEF)
                    plan_tile_set[r.tile_number][r.pixel_index] = 1'b1;
            stc_pkg::OP_SPRITE_WR:
                plan_sprite_set[r.pixel_index] = 1'b1;
            default: ;
        endcase
        request_queue.push_back(r);
        queued_requests++;
    endtask

    // A render first loads, with random content, any entry it would read
    // that has never been written.
    task automatic queue_request(stc_pkg::in_t r);
        int           mx, tx, ty, pidx, dx, dy;
        stc_pkg::in_t w;
        if (r.opcode == stc_pkg::OP_RENDER && r.pos_x < stc_pkg::SCREEN_WIDTH
            && r.pos_y < stc_pkg::SCREEN_HEIGHT) begin
            mx = cam_cfg + int'(r.pos_x);
            tx = mx / stc_pkg::TILE_EDGE;
            ty = int'(r.pos_y) / stc_pkg::TILE_EDGE;
            if (tx < stc_pkg::MAP_COLUMNS_DEF && ty < stc_pkg::MAP_ROW_COUNT_DEF) begin
                if (!plan_map_set[ty][tx]) begin
                    w            = random_request(stc_pkg::OP_MAP_WR);
                    w.map_row    = ty[3:0];
                    w.map_column = tx[7:0];
                    push_request(w);
                end
                pidx = (int'(r.pos_y) % stc_pkg::TILE_EDGE) * stc_pkg::TILE_EDGE
                     + mx % stc_pkg::TILE_EDGE;
                if (!plan_tile_set[plan_map[ty][tx]][pidx]) begin
                    w             = random_request(stc_pkg::OP_TILE_WR);
                    w.tile_number = plan_map[ty][tx];
                    w.pixel_index = pidx[7:0];
                    push_request(w);
                end
            end
            dx = mx - spr_x_cfg;
            dy = int'(r.pos_y) - spr_y_cfg;
            if (dx >= 0 && dx < stc_pkg::TILE_EDGE && dy >= 0 && dy < stc_pkg::TILE_EDGE
                && !plan_sprite_set[dy * stc_pkg::TILE_EDGE + dx]) begin
                w             = random_request(stc_pkg::OP_SPRITE_WR);
                w.pixel_index = 8'(dy * stc_pkg::TILE_EDGE + dx);
                push_request(w);
            end
        end
        push_request(r);
    endtask

    // Counts every queued request, including the store loads a render pulls in.
    task automatic random_traffic(int count);
        int           pick, x, y, col, start;
        stc_pkg::in_t r;
        start = queued_requests;
        while (queued_requests - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                r = random_request(stc_pkg::OP_RENDER);
                if ($urandom_range(0, 9) != 0) begin
                    r.pos_x = 9'($urandom_range(0, stc_pkg::SCREEN_WIDTH - 1));
                    r.pos_y = 8'($urandom_range(0, stc_pkg::SCREEN_HEIGHT - 1));
                end
                // Aim a third of the renders at and around the sprite box.
                if ($urandom_range(0, 2) == 0) begin
                    x = spr_x_cfg - cam_cfg + int'($urandom_range(0, 19)) - 2;
                    y = spr_y_cfg + int'($urandom_range(0, 19)) - 2;
                    if (x >= 0 && x < stc_pkg::SCREEN_WIDTH)
                        r.pos_x = x[8:0];
                    if (y >= 0 && y < stc_pkg::SCREEN_HEIGHT)
                        r.pos_y = y[7:0];
                end
            end
            else if (pick < 70) begin
                r   = random_request(stc_pkg::OP_MAP_WR);
                col = cam_cfg / stc_pkg::TILE_EDGE + int'($urandom_range(0, 20));
                if ($urandom_range(0, 3) != 0 && col < stc_pkg::MAP_COLUMNS_DEF)
                    r.map_column = col[7:0];
            end
            else if (pick < 85)
                r = random_request(stc_pkg::OP_TILE_WR);
            else
                r = random_request(stc_pkg::OP_SPRITE_WR);
            queue_request(r);
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            stc_pkg::REG_CAMERA_X:   cam_cfg   = int'(value[11:0]);
            stc_pkg::REG_SPRITE_X:   spr_x_cfg = $signed(value[12:0]);
            stc_pkg::REG_SPRITE_Y:   spr_y_cfg = $signed(value[8:0]);
            stc_pkg::REG_BACKGROUND: bg_cfg    = int'(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(int cam, int spx, int spy, int colour);
        write_register(stc_pkg::REG_CAMERA_X, cam);
        write_register(stc_pkg::REG_SPRITE_X, spx);
        write_register(stc_pkg::REG_SPRITE_Y, spy);
        write_register(stc_pkg::REG_BACKGROUND, colour);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Waits until every queued request is in and every pixel is out, then
    // lets writes still in the pipeline retire.
    task automatic settle();
        do
            @(negedge clk);
        while (accepted_requests != queued_requests || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_req  = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, drv_req.pos_y, drv_req.pos_x,
                             drv_req.colour_value, drv_req.pixel_index,
                             drv_req.tile_number, drv_req.map_column, drv_req.map_row};
                s_tuser  <= drv_req.opcode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result sink with random stalls and one long hold-off.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : monitor
        stc_pkg::in_t  seen;
        stc_pkg::res_t want;
        stc_pkg::res_t got;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                seen.opcode       = stc_pkg::op_t'(s_tuser);
                seen.map_row      = s_tdata[3:0];
                seen.map_column   = s_tdata[11:4];
                seen.tile_number  = s_tdata[15:12];
                seen.pixel_index  = s_tdata[23:16];
                seen.colour_value = s_tdata[39:24];
                seen.pos_x        = s_tdata[48:40];
                seen.pos_y        = s_tdata[56:49];
                accepted_requests++;
                if (composite_pixel(seen, want))
                    expected_pixels.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[24:16], m_tdata[32:25], m_tuser[0]};
                if (expected_pixels.size() == 0) begin
                    $error("pixel at x=%0d y=%0d with no render pending",
                           got.out_x, got.out_y);
                    mismatches++;
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_colour !== want.pixel_colour) begin
                        $error("pixel_colour: expected %h, got %h",
                               want.pixel_colour, got.pixel_colour);
                        mismatches++;
                    end
                    if (got.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
                        mismatches++;
                    end
                    if (got.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
                        mismatches++;
                    end
                    if (got.sprite_hit !== want.sprite_hit) begin
                        $error("sprite_hit: expected %0d, got %0d",
                               want.sprite_hit, got.sprite_hit);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Ends the run when no request and no pixel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL scrolling_tilemap_sprite_compositor_unit");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int cam, spx, spy;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset register values. Map entries are four
        // bits wide, so every stored id names a known tile at this size.
        @(negedge clk);
        queue_request(build(stc_pkg::OP_MAP_WR, 0, 0, 3, 0, 0, 0, 0));
        queue_request(build(stc_pkg::OP_MAP_WR, 0, 1, 0, 0, 0, 0, 0));
        queue_request(build(stc_pkg::OP_MAP_WR, 14, 19, 15, 0, 0, 0, 0));
        queue_request(build(stc_pkg::OP_MAP_WR, 14, 255, 15, 0, 0, 0, 0));
        // Row past the end of the map: the write is dropped.
        queue_request(build(stc_pkg::OP_MAP_WR, 15, 7, 9, 0, 0, 0, 0));
        // A black tile pixel is drawn as is; only the sprite is keyed.
        queue_request(build(stc_pkg::OP_TILE_WR, 0, 0, 3, 0, 16'h0000, 0, 0));
        queue_request(build(stc_pkg::OP_TILE_WR, 0, 0, 3, 1, 16'h0F0F, 0, 0));
        queue_request(build(stc_pkg::OP_TILE_WR, 0, 0, 3, 255, 16'hFFFF, 0, 0));
        queue_request(build(stc_pkg::OP_TILE_WR, 0, 0, 0, 17, 16'h1234, 0, 0));
        queue_request(build(stc_pkg::OP_TILE_WR, 0, 0, 15, 255, 16'hABCD, 0, 0));
        queue_request(build(stc_pkg::OP_SPRITE_WR, 0, 0, 0, 0, 16'h0000, 0, 0));
        queue_request(build(stc_pkg::OP_SPRITE_WR, 0, 0, 0, 1, 16'hF800, 0, 0));
        queue_request(build(stc_pkg::OP_SPRITE_WR, 0, 0, 0, 255, 16'h07E0, 0, 0));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 1, 0));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 15, 15));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 17, 1));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 319, 239));
        // Off-screen renders give no pixel.
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 320, 0));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 240));
        queue_request(build(stc_pkg::OP_RENDER, 0, 0, 0, 0, 0, 511, 255));
        settle();

        // Register extremes, including a camera that runs past the map end.
        apply_settings(0, -16, -16, 16'h0000);
        set_idling(0, 0);
        random_traffic(80);
        settle();

        apply_settings(4095, 4095, 255, 16'hFFFF);
        set_idling(88, 0);
        random_traffic(60);
        settle();

        apply_settings(3900, 3990, 100, $urandom_range(0, 65535));
        set_idling(0, 88);
        random_traffic(80);
        settle();

        for (int p = 0; p < 6; p++) begin
            cam = ($urandom_range(0, 3) == 0) ? $urandom_range(3700, 4095)
                                              : $urandom_range(0, 3700);
            spx = cam + int'($urandom_range(0, 340)) - 16;
            if (spx > 4095)
                spx = 4095;
            spy = int'($urandom_range(0, 256)) - 16;
            apply_settings(cam, spx, spy, $urandom_range(0, 65535));
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(88, 0);
                2: set_idling(0, 88);
                default: set_idling(35, 35);
            endcase
            // First pass of the loop: the sink holds off while requests keep coming.
            if (p == 0)
                hold_arm = 1'b1;
            random_traffic(70);
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS scrolling_tilemap_sprite_compositor_unit");
        else
            $display("FAIL scrolling_tilemap_sprite_compositor_unit");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/stc_pkg.sv
rtl/stc_ram.sv
rtl/stc_queue.sv
rtl/stc_front.sv
rtl/stc_back.sv
rtl/scrolling_tilemap_sprite_compositor_unit.sv
tb/scrolling_tilemap_sprite_compositor_unit_tb.sv
